>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame formatter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/htff_pkg.sv
// ----------------------------------------------------------------------------
// htff_pkg
// Types, constants and character helpers of the humidity/temperature
// frame formatter.
// ----------------------------------------------------------------------------
package htff_pkg;

    // Widths
    localparam int RAW_W    = 20;
    localparam int VAL_W    = 14;
    localparam int DIG_W    = 4;
    localparam int NUM_DIG  = 4;
    localparam int LINE_LEN = 20;
    localparam int IDX_W    = 5;
    localparam int POS_W    = 3;
    localparam int PROD_W   = 30;
    localparam int RECIP_W  = 13;

    // Frame byte positions
    localparam logic [POS_W-1:0] POS_STATUS = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST   = 3'd5;

    // Conversion constants
    localparam logic [9:0]         SCALE_MUL   = 10'd625;
    localparam int                 TEMP_SHIFT  = 15;
    localparam int                 HUM_SHIFT   = 16;
    localparam logic [14:0]        TEMP_OFFSET = 15'd5000;
    localparam logic [14:0]        TEMP_TOP    = 15'd14999;
    localparam logic [VAL_W-1:0]   VAL_MAX     = 14'd9999;
    localparam logic [RECIP_W-1:0] RECIP_10    = 13'd6554;
    localparam int                 RECIP_SHIFT = 16;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] ASCII_NL    = 8'h0A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_COLON = 8'h3A;

    // Line positions that carry digits or the end of line
    localparam logic [IDX_W-1:0] IDX_T3   = 5'd4;
    localparam logic [IDX_W-1:0] IDX_T2   = 5'd5;
    localparam logic [IDX_W-1:0] IDX_T1   = 5'd7;
    localparam logic [IDX_W-1:0] IDX_T0   = 5'd8;
    localparam logic [IDX_W-1:0] IDX_H3   = 5'd14;
    localparam logic [IDX_W-1:0] IDX_H2   = 5'd15;
    localparam logic [IDX_W-1:0] IDX_H1   = 5'd17;
    localparam logic [IDX_W-1:0] IDX_H0   = 5'd18;
    localparam logic [IDX_W-1:0] IDX_LAST = 5'(LINE_LEN - 1);

    // Fixed text of the line; digit slots hold zero
    localparam logic [7:0] LINE_TEXT [LINE_LEN] = '{
        8'h73, 8'h69, 8'h63, ASCII_COLON, 8'h00, 8'h00, ASCII_COMMA, 8'h00, 8'h00,
        ASCII_SPACE, 8'h6E, 8'h65, 8'h6D, ASCII_COLON, 8'h00, 8'h00, ASCII_COMMA,
        8'h00, 8'h00, ASCII_NL
    };

    // Raw words of one frame
    typedef struct packed {
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] tmp_raw;
    } t_frame;

    // Decimal digits, index 0 is the ones digit
    typedef struct packed {
        logic [NUM_DIG-1:0][DIG_W-1:0] tmp_dig;
        logic [NUM_DIG-1:0][DIG_W-1:0] hum_dig;
    } t_digits;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        return ASCII_ZERO | {4'b0000, d};
    endfunction

    function automatic logic [7:0] line_char(input logic [IDX_W-1:0] idx,
                                             input t_digits d);
        logic [7:0] c;
        case (idx)
            IDX_T3:  c = digit_char(d.tmp_dig[3]);
            IDX_T2:  c = digit_char(d.tmp_dig[2]);
            IDX_T1:  c = digit_char(d.tmp_dig[1]);
            IDX_T0:  c = digit_char(d.tmp_dig[0]);
            IDX_H3:  c = digit_char(d.hum_dig[3]);
            IDX_H2:  c = digit_char(d.hum_dig[2]);
            IDX_H1:  c = digit_char(d.hum_dig[1]);
            IDX_H0:  c = digit_char(d.hum_dig[0]);
            default: c = (idx <= IDX_LAST) ? LINE_TEXT[idx] : ASCII_NL;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/htff_front.sv
// ----------------------------------------------------------------------------
// htff_front
// Accepts frame bytes, tracks the byte position and assembles the raw
// humidity and temperature words, pushing one record per frame.
// ----------------------------------------------------------------------------
module htff_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_frame_byte,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output htff_pkg::t_frame     o_push_data
);
    import htff_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_store [4];
    logic [POS_W-1:0] store_idx;
    logic             accept;

    // Stall only on the last byte when the queue is full
    assign o_push_valid = i_valid && (r_pos == POS_LAST);
    assign o_ready      = (r_pos != POS_LAST) || i_push_ready;
    assign accept       = i_valid && o_ready;
    assign store_idx    = r_pos - POS_FIRST;

    // Assemble the raw words from the stored bytes and the last byte
    assign o_push_data.hum_raw = {r_store[0], r_store[1], r_store[2][7:4]};
    assign o_push_data.tmp_raw = {r_store[2][3:0], r_store[3], i_frame_byte};

    // Advance the byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_STATUS;
        end else if (accept) begin
            if (r_pos == POS_STATUS || r_pos > POS_LAST) begin
                r_pos <= POS_FIRST;
            end else if (r_pos < POS_LAST) begin
                r_pos <= r_pos + POS_FIRST;
            end else begin
                r_pos <= POS_STATUS;
            end
        end
    end

    // Hold data bytes one to four
    always_ff @(posedge i_clk) begin
        if (accept && r_pos != POS_STATUS && r_pos < POS_LAST) begin
            r_store[store_idx[1:0]] <= i_frame_byte;
        end
    end

endmodule

>>> hw/rtl/htff_fifo.sv
// ----------------------------------------------------------------------------
// htff_fifo
// Two-entry queue of frame records between the front and the converter.
// ----------------------------------------------------------------------------
module htff_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  htff_pkg::t_frame     i_push_data,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output htff_pkg::t_frame     o_pop_data
);
    import htff_pkg::*;

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Write the entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> hw/rtl/htff_conv.sv
// ----------------------------------------------------------------------------
// htff_conv
// Scales the raw words, clamps them and splits each value into four
// decimal digits by three divide-by-ten steps.
// ----------------------------------------------------------------------------
module htff_conv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  htff_pkg::t_frame     i_frame,
    output logic                 o_valid,
    input  logic                 i_ready,
    output htff_pkg::t_digits    o_digits
);
    import htff_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_DIV, ST_DONE} t_state;

    t_state                          r_state;
    logic [1:0]                      r_step;
    logic [PROD_W-1:0]               r_tprod;
    logic [PROD_W-1:0]               r_hprod;
    logic [VAL_W-1:0]                r_tval;
    logic [VAL_W-1:0]                r_hval;
    logic [NUM_DIG-1:0][DIG_W-1:0]   r_tdig;
    logic [NUM_DIG-1:0][DIG_W-1:0]   r_hdig;

    logic [14:0]                     t_scaled;
    logic [VAL_W-1:0]                h_scaled;
    logic [VAL_W-1:0]                t_clamp;
    logic [VAL_W-1:0]                h_clamp;
    logic [VAL_W+RECIP_W-1:0]        t_recip;
    logic [VAL_W+RECIP_W-1:0]        h_recip;
    logic [VAL_W-1:0]                t_q;
    logic [VAL_W-1:0]                h_q;
    logic [VAL_W-1:0]                t_rem;
    logic [VAL_W-1:0]                h_rem;

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = (r_state == ST_DONE);
    assign o_digits.tmp_dig = r_tdig;
    assign o_digits.hum_dig = r_hdig;

    // Scale and clamp
    always_comb begin
        t_scaled = 15'(r_tprod >> TEMP_SHIFT);
        h_scaled = VAL_W'(r_hprod >> HUM_SHIFT);
        if (t_scaled < TEMP_OFFSET) begin
            t_clamp = '0;
        end else if (t_scaled > TEMP_TOP) begin
            t_clamp = VAL_MAX;
        end else begin
            t_clamp = VAL_W'(t_scaled - TEMP_OFFSET);
        end
        h_clamp = (h_scaled > VAL_MAX) ? VAL_MAX : h_scaled;
    end

    // Divide by ten through the reciprocal, exact below ten thousand
    always_comb begin
        t_recip = r_tval * RECIP_10;
        h_recip = r_hval * RECIP_10;
        t_q     = VAL_W'(t_recip >> RECIP_SHIFT);
        h_q     = VAL_W'(h_recip >> RECIP_SHIFT);
        t_rem   = r_tval - VAL_W'((t_q << 3) + (t_q << 1));
        h_rem   = r_hval - VAL_W'((h_q << 3) + (h_q << 1));
    end

    // Sequence one frame through scale and digit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 2'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_tprod <= PROD_W'(i_frame.tmp_raw * SCALE_MUL);
                        r_hprod <= PROD_W'(i_frame.hum_raw * SCALE_MUL);
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_tval  <= t_clamp;
                    r_hval  <= h_clamp;
                    r_step  <= 2'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_tval <= t_q;
                    r_hval <= h_q;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_tdig  <= {t_q[DIG_W-1:0], t_rem[DIG_W-1:0], r_tdig[3:2]};
                        r_hdig  <= {h_q[DIG_W-1:0], h_rem[DIG_W-1:0], r_hdig[3:2]};
                        r_state <= ST_DONE;
                    end else begin
                        r_tdig <= {t_rem[DIG_W-1:0], r_tdig[3:1]};
                        r_hdig <= {h_rem[DIG_W-1:0], r_hdig[3:1]};
                    end
                end
                ST_DONE: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/htff_emit.sv
// ----------------------------------------------------------------------------
// htff_emit
// Walks the twenty characters of one line into a registered output slot.
// ----------------------------------------------------------------------------
module htff_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  htff_pkg::t_digits    i_digits,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_ascii_char,
    output logic                 o_last_char
);
    import htff_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_digits          r_dig;
    logic             r_out_valid;
    logic [7:0]       r_char;
    logic             r_last;
    logic             slot_free;

    assign slot_free    = !r_out_valid || i_ready;
    assign o_ready      = !r_busy;
    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

    // Load a line, then advance one character per free output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !r_busy) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_dig  <= i_digits;
            end
            if (r_busy && slot_free) begin
                r_char      <= line_char(r_idx, r_dig);
                r_last      <= (r_idx == IDX_LAST);
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 5'd1;
                if (r_idx == IDX_LAST) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/humidity_temperature_frame_formatter_unit.sv
// Throughput: one character per cycle within a line while the output is ready, with an
// idle gap between lines, so the emitter sets the sustained frame rate. The front takes
// one byte per cycle unless the queue is full on a frame's last byte; a two-entry queue
// buffers whole frames. Reset: synchronous, active low; clears byte position, queue and
// sequencers.
// ----------------------------------------------------------------------------
// humidity_temperature_frame_formatter_unit
// Turns six-byte humidity/temperature sensor frames into ASCII text lines.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_formatter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_frame_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_ascii_char,
    output logic       o_last_char
);
    import htff_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_frame  push_data;
    logic    pop_valid;
    logic    pop_ready;
    t_frame  pop_data;
    logic    dig_valid;
    logic    dig_ready;
    t_digits digits;

    // Accept and assemble frames
    htff_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_byte (i_frame_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Buffer frame records
    htff_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Convert to decimal digits
    htff_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop_valid),
        .o_ready  (pop_ready),
        .i_frame  (pop_data),
        .o_valid  (dig_valid),
        .i_ready  (dig_ready),
        .o_digits (digits)
    );

    // Emit the text line
    htff_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dig_valid),
        .o_ready      (dig_ready),
        .i_digits     (digits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

>>> hw/rtl/htff_checker.sv
// ----------------------------------------------------------------------------
// htff_checker
// Port-level checks of the formatter output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htff_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_ascii_char,
    input logic       o_last_char
);
    import htff_pkg::*;

    // Hold a stalled character
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_ascii_char) && $stable(o_last_char))
    // Flag the newline as end of line
    `AST_IMP(a_last_is_nl, i_clk, i_rst_n, o_valid && o_last_char, o_ascii_char == ASCII_NL)
    // Allow no newline inside a line
    `AST_IMP(a_nl_is_last, i_clk, i_rst_n, o_valid && o_ascii_char == ASCII_NL, o_last_char)
    // Start each new line with its first fixed character
    `AST_NEXT(a_line_start, i_clk, i_rst_n, o_valid && i_ready && o_last_char, !o_valid || o_ascii_char == LINE_TEXT[0])

endmodule

bind humidity_temperature_frame_formatter_unit htff_checker u_htff_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_ascii_char (o_ascii_char),
    .o_last_char  (o_last_char)
);
